[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/lcg_pkg.sv]
`timescale 1ns / 1ps

package lcg_pkg;

	localparam int STATE_BITS = 32;

	localparam int VAL_W  = 32;
	localparam int MOD_W  = 33;
	localparam int CNT_W  = $clog2(VAL_W);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [MOD_W-1:0] MAX_MODULUS = (STATE_BITS >= VAL_W) ?
		(MOD_W'(1) << VAL_W) : (MOD_W'(1) << STATE_BITS);

	localparam logic [VAL_W-1:0] MULTIPLIER_RST = 32'd1664525;
	localparam logic [VAL_W-1:0] INCREMENT_RST  = 32'd1013904223;
	localparam logic [MOD_W-1:0] MODULUS_RST    = 33'h1_0000_0000;

	localparam logic KIND_GENERATE = 1'b0;
	localparam logic KIND_LOAD     = 1'b1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_SEED   = 2'd1;
	localparam logic [1:0] STATUS_BAD_PARAMS = 2'd2;

	typedef enum logic [1:0] {
		REG_MULTIPLIER = 2'd0,
		REG_INCREMENT  = 2'd1,
		REG_MODULUS    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CHECK,
		S_GCD,
		S_IDLE,
		S_REDX,
		S_MUL,
		S_ADDC,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] fraction;
		logic [1:0]       status;
	} rsp_t;

endpackage

[rtl/linear_congruential_generator.sv]
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | kind, seed_value
// rsp     | out       | rsp_valid / rsp_ready | value, fraction, status
// cfg     | in        | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Generate: state reduction, modular multiply and fraction division, each one bit a
// cycle through a shared shift-and-reduce unit.
// Load: fraction division only; error results go straight to the completion state.
// After reset and after every register write the parameter check runs (with a binary
// gcd, one step a cycle, once the basic checks pass); req_ready stays low meanwhile.
// A result waiting in the output register does not stop the next request.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_congruential_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  lcg_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output lcg_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lcg_pkg::ADDR_W-1:0]   paddr,
	input  logic [lcg_pkg::DATA_W-1:0]   pwdata,
	output logic [lcg_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam logic [lcg_pkg::CNT_W-1:0] CNT_LAST = lcg_pkg::CNT_W'(lcg_pkg::VAL_W - 1);

	lcg_pkg::state_t state_q, state_d;

	logic [lcg_pkg::VAL_W-1:0] mult_q, inc_q, cur_q, r_q, xr_q, sh_q;
	logic [lcg_pkg::MOD_W-1:0] mod_q, u_q, v_q;
	logic [lcg_pkg::CNT_W-1:0] cnt_q;
	logic                      ok_q;
	logic [1:0]                status_q;
	lcg_pkg::rsp_t             rsp_q;
	logic                      rsp_valid_q;

	logic cfg_wr, accept, last, out_load;
	logic params_bad, both_even, seed_bad, gcd_done;
	logic dbl, ge1, ge2;
	logic [lcg_pkg::MOD_W:0] base, addend, t, m1, m2, t_red;
	logic [lcg_pkg::VAL_W-1:0] r_next;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign req_ready = (state_q == lcg_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;
	assign last      = (cnt_q == CNT_LAST);
	assign out_load  = (state_q == lcg_pkg::S_DONE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= lcg_pkg::MULTIPLIER_RST;
			inc_q  <= lcg_pkg::INCREMENT_RST;
			mod_q  <= lcg_pkg::MODULUS_RST;
		end else if (cfg_wr) begin
			case (lcg_pkg::reg_idx_t'(paddr[lcg_pkg::ADDR_W-1:3]))
				lcg_pkg::REG_MULTIPLIER: mult_q <= pwdata[lcg_pkg::VAL_W-1:0];
				lcg_pkg::REG_INCREMENT:  inc_q  <= pwdata[lcg_pkg::VAL_W-1:0];
				lcg_pkg::REG_MODULUS:    mod_q  <= pwdata[lcg_pkg::MOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (lcg_pkg::reg_idx_t'(paddr[lcg_pkg::ADDR_W-1:3]))
			lcg_pkg::REG_MULTIPLIER: prdata = {{(lcg_pkg::DATA_W-lcg_pkg::VAL_W){1'b0}}, mult_q};
			lcg_pkg::REG_INCREMENT:  prdata = {{(lcg_pkg::DATA_W-lcg_pkg::VAL_W){1'b0}}, inc_q};
			lcg_pkg::REG_MODULUS:    prdata = {{(lcg_pkg::DATA_W-lcg_pkg::MOD_W){1'b0}}, mod_q};
			default:                 prdata = '0;
		endcase
	end

	// parameter checks
	assign params_bad = (mod_q == '0) || (mod_q > lcg_pkg::MAX_MODULUS) ||
		({1'b0, mult_q} >= mod_q) || ({1'b0, inc_q} >= mod_q);
	assign both_even  = !inc_q[0] && !mod_q[0];
	assign seed_bad   = ({1'b0, req.seed_value} >= mod_q);
	assign gcd_done   = u_q[0] && v_q[0] && (u_q == v_q);

	// shift-and-reduce unit: t = 2r + addend (or r + addend), minus 0, m or 2m
	always_comb begin
		dbl = (state_q != lcg_pkg::S_ADDC);
		case (state_q)
			lcg_pkg::S_REDX: addend = {{lcg_pkg::MOD_W{1'b0}}, sh_q[lcg_pkg::VAL_W-1]};
			lcg_pkg::S_MUL:  addend = sh_q[lcg_pkg::VAL_W-1] ? {2'b00, xr_q} : '0;
			lcg_pkg::S_ADDC: addend = {2'b00, inc_q};
			default:         addend = '0;
		endcase
		base  = dbl ? {1'b0, r_q, 1'b0} : {2'b00, r_q};
		t     = base + addend;
		m1    = {1'b0, mod_q};
		m2    = {mod_q, 1'b0};
		ge2   = (t >= m2);
		ge1   = (t >= m1);
		t_red = ge2 ? (t - m2) : (ge1 ? (t - m1) : t);
		r_next = t_red[lcg_pkg::VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcg_pkg::S_CHECK;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lcg_pkg::S_CHECK: begin
				if (params_bad || (inc_q == '0) || both_even) begin
					state_d = lcg_pkg::S_IDLE;
				end else begin
					state_d = lcg_pkg::S_GCD;
				end
			end
			lcg_pkg::S_GCD: begin
				if (gcd_done) begin
					state_d = lcg_pkg::S_IDLE;
				end
			end
			lcg_pkg::S_IDLE: begin
				if (accept) begin
					if (!ok_q) begin
						state_d = lcg_pkg::S_DONE;
					end else if (req.kind == lcg_pkg::KIND_LOAD) begin
						state_d = seed_bad ? lcg_pkg::S_DONE : lcg_pkg::S_DIV;
					end else begin
						state_d = lcg_pkg::S_REDX;
					end
				end
			end
			lcg_pkg::S_REDX: begin
				if (last) begin
					state_d = lcg_pkg::S_MUL;
				end
			end
			lcg_pkg::S_MUL: begin
				if (last) begin
					state_d = lcg_pkg::S_ADDC;
				end
			end
			lcg_pkg::S_ADDC: state_d = lcg_pkg::S_DIV;
			lcg_pkg::S_DIV: begin
				if (last) begin
					state_d = lcg_pkg::S_DONE;
				end
			end
			lcg_pkg::S_DONE: begin
				if (out_load) begin
					state_d = lcg_pkg::S_IDLE;
				end
			end
			default: state_d = lcg_pkg::S_CHECK;
		endcase
		// restart the check on any register write
		if (cfg_wr) begin
			state_d = lcg_pkg::S_CHECK;
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b0;
			cur_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				lcg_pkg::S_CHECK: ok_q <= !params_bad && (inc_q == '0);
				lcg_pkg::S_GCD: begin
					if (gcd_done) begin
						ok_q <= (u_q == lcg_pkg::MOD_W'(1));
					end
				end
				lcg_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (accept && ok_q && req.kind == lcg_pkg::KIND_LOAD && !seed_bad) begin
						cur_q <= req.seed_value;
					end
				end
				lcg_pkg::S_REDX, lcg_pkg::S_MUL, lcg_pkg::S_DIV: cnt_q <= cnt_q + 1'b1;
				lcg_pkg::S_ADDC: begin
					cur_q <= r_next;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		case (state_q)
			lcg_pkg::S_CHECK: begin
				u_q <= {1'b0, inc_q};
				v_q <= mod_q;
			end
			lcg_pkg::S_GCD: begin
				if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= u_q - v_q;
				end else if (v_q > u_q) begin
					v_q <= v_q - u_q;
				end
			end
			lcg_pkg::S_IDLE: begin
				if (accept) begin
					if (!ok_q) begin
						status_q <= lcg_pkg::STATUS_BAD_PARAMS;
						sh_q     <= '0;
					end else if (req.kind == lcg_pkg::KIND_LOAD) begin
						if (seed_bad) begin
							status_q <= lcg_pkg::STATUS_BAD_SEED;
							sh_q     <= '0;
						end else begin
							status_q <= lcg_pkg::STATUS_OK;
							r_q      <= req.seed_value;
						end
					end else begin
						status_q <= lcg_pkg::STATUS_OK;
						sh_q     <= cur_q;
						r_q      <= '0;
					end
				end
			end
			lcg_pkg::S_REDX: begin
				if (last) begin
					xr_q <= r_next;
					r_q  <= '0;
					sh_q <= mult_q;
				end else begin
					r_q  <= r_next;
					sh_q <= sh_q << 1;
				end
			end
			lcg_pkg::S_MUL: begin
				r_q  <= r_next;
				sh_q <= sh_q << 1;
			end
			lcg_pkg::S_ADDC: r_q <= r_next;
			lcg_pkg::S_DIV: begin
				r_q  <= r_next;
				sh_q <= {sh_q[lcg_pkg::VAL_W-2:0], ge1};
			end
			default: ;
		endcase
	end

	// output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.value    <= cur_q;
			rsp_q.fraction <= sh_q;
			rsp_q.status   <= status_q;
		end
	end

	`ASSERT_CLK(a_residue_below_mod, (state_q == lcg_pkg::S_REDX || state_q == lcg_pkg::S_MUL || state_q == lcg_pkg::S_ADDC || state_q == lcg_pkg::S_DIV) |-> ({1'b0, r_q} < mod_q), "residue not below modulus")
	`ASSERT_NEVER(a_gcd_nonzero, state_q == lcg_pkg::S_GCD && (u_q == '0 || v_q == '0), "gcd operand reached zero")
	`ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid_q) |-> $past(state_q == lcg_pkg::S_DONE), "result loaded outside completion state")

endmodule
